@@ hdl/sbrc_pkg.sv @@
// Shared types and constants of the SPI banked register command slave.
package sbrc_pkg;

  // Buffer depth must be a power of two; pointers wrap by masking.
  localparam int unsigned BufferDepth = 8192;
  localparam int unsigned BankCount   = 4;
  localparam int unsigned BufAw       = $clog2(BufferDepth);
  localparam int unsigned RegDepth    = 128;
  localparam int unsigned RegAw       = $clog2(RegDepth);

  localparam logic [1:0] BankMax = 2'(BankCount - 1);

  localparam logic [4:0] AddrSharedFirst = 5'h1B;
  localparam logic [4:0] AddrDummyLast   = 5'h05;
  localparam logic [4:0] AddrDummyExtra  = 5'h0A;
  localparam logic [1:0] BankDummyAll    = 2'd2;
  localparam logic [1:0] BankDummySome   = 2'd3;

  localparam logic [RegAw-1:0] IdxBankSel = RegAw'(8'h1F);

  typedef enum logic [2:0] {
    OpRdReg  = 3'd0,
    OpRdBuf  = 3'd1,
    OpWrReg  = 3'd2,
    OpWrBuf  = 3'd3,
    OpBitSet = 3'd4,
    OpBitClr = 3'd5,
    OpUnused = 3'd6,
    OpReset  = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhData  = 2'd1,
    PhDummy = 2'd2,
    PhDone  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SrcConst = 2'd0,
    SrcReg   = 2'd1,
    SrcBuf   = 2'd2
  } miso_src_e;

  // Request handed from the decode stage to the memory stage.
  typedef struct packed {
    miso_src_e        src;
    logic [7:0]       value;
    logic             wr;
    opcode_e          op;
    logic [RegAw-1:0] idx;
    logic [7:0]       data;
  } s0_req_t;

endpackage

@@ hdl/spi_banked_register_command_slave.sv @@
// Device side of an SPI command interface: each input item is one MOSI byte (tuser marks the
// first byte after chip select) and each yields exactly one MISO byte. The block takes one
// item per clock unless the output is stalled; a result passes through the synchronous read of
// the register or buffer memory and then through the output register. Register bytes sit in a
// 128-entry memory with a valid bit per entry, so reset and the reset command take effect at
// once with no clearing pass; the bank select and the buffer pointers are held in flip-flops.
// The buffer memory is not cleared and its depth is a power of two.
module spi_banked_register_command_slave (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] mosi_byte
  input  logic       s_axis_tuser_i,   // [0] frame_start
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [7:0] miso_byte
);
  import sbrc_pkg::*;

  logic             accept;
  s0_req_t          req;
  logic             clear_all;
  logic             reg_re, reg_we;
  logic [RegAw-1:0] reg_raddr, reg_waddr;
  logic [7:0]       reg_rdata, reg_wdata;
  logic             buf_re, buf_we;
  logic [BufAw-1:0] buf_raddr, buf_waddr;
  logic [7:0]       buf_rdata, buf_wdata;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  sbrc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (s_axis_tuser_i),
    .mosi_byte_i   (s_axis_tdata_i),
    .req_o         (req),
    .clear_all_o   (clear_all),
    .reg_re_o      (reg_re),
    .reg_raddr_o   (reg_raddr),
    .buf_re_o      (buf_re),
    .buf_raddr_o   (buf_raddr),
    .buf_we_o      (buf_we),
    .buf_waddr_o   (buf_waddr),
    .buf_wdata_o   (buf_wdata)
  );

  sbrc_ram #(
    .Width (8),
    .Depth (RegDepth)
  ) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .re_i    (reg_re),
    .raddr_i (reg_raddr),
    .rdata_o (reg_rdata)
  );

  sbrc_ram #(
    .Width (8),
    .Depth (BufferDepth)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  sbrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req),
    .clear_all_i (clear_all),
    .reg_rdata_i (reg_rdata),
    .buf_rdata_i (buf_rdata),
    .reg_we_o    (reg_we),
    .reg_waddr_o (reg_waddr),
    .reg_wdata_o (reg_wdata),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // Registers held in flip-flops must never be written through the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reg_we |-> !((reg_waddr[RegAw-1:2] == '0) || (reg_waddr == IdxBankSel)))
    else $error("register memory write hits a flip-flop register");

  // The buffer is never read and written by the same item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(buf_re && buf_we))
    else $error("buffer read and write in one cycle");

  // A reset command never accesses the register memory or the buffer memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_all |-> (!reg_re && !buf_re && !buf_we))
    else $error("reset command issued a memory access");

  // An item taken while the output is stalled waits in the memory stage, so no result is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && m_axis_tvalid_o && !m_axis_tready_i) |=> !s_axis_tready_o || m_axis_tvalid_o)
    else $error("result lost under output stall");

endmodule

@@ hdl/sbrc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module sbrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sbrc_front.sv @@
// Command decode stage: transaction phase, bank select and buffer pointers.
module sbrc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         frame_start_i,
  input  logic [7:0]                   mosi_byte_i,
  output sbrc_pkg::s0_req_t            req_o,
  output logic                         clear_all_o,
  output logic                         reg_re_o,
  output logic [sbrc_pkg::RegAw-1:0]   reg_raddr_o,
  output logic                         buf_re_o,
  output logic [sbrc_pkg::BufAw-1:0]   buf_raddr_o,
  output logic                         buf_we_o,
  output logic [sbrc_pkg::BufAw-1:0]   buf_waddr_o,
  output logic [7:0]                   buf_wdata_o
);
  import sbrc_pkg::*;

  phase_e           phase_q, phase_d;
  opcode_e          opcode_q, opcode_d;
  logic [4:0]       addr_q, addr_d;
  logic [7:0]       bank_sel_q, bank_sel_d;
  logic [3:0][7:0]  ptr_q, ptr_d;

  logic [1:0]       bank;
  logic [RegAw-1:0] idx;
  logic             is_shadow;
  logic [7:0]       shadow_val;
  logic [7:0]       shadow_new;
  logic             needs_dummy;
  logic [4:0]       new_addr;
  logic [15:0]      rp_word, wp_word;
  logic [BufAw-1:0] rp_cur, wp_cur, rp_inc, wp_inc;

  assign bank = (bank_sel_q[1:0] > BankMax) ? BankMax : bank_sel_q[1:0];
  assign idx  = (addr_q >= AddrSharedFirst) ? RegAw'(addr_q) : {bank, addr_q};

  // Bank select and the four pointer bytes of bank 0 live in flip-flops.
  assign is_shadow  = (idx[RegAw-1:2] == '0) || (idx == IdxBankSel);
  assign shadow_val = (idx == IdxBankSel) ? bank_sel_q : ptr_q[idx[1:0]];

  always_comb begin
    case (opcode_q)
      OpWrReg:  shadow_new = mosi_byte_i;
      OpBitSet: shadow_new = shadow_val | mosi_byte_i;
      default:  shadow_new = shadow_val & ~mosi_byte_i;
    endcase
  end

  assign new_addr    = mosi_byte_i[4:0];
  assign needs_dummy = ((bank == BankDummyAll) && (new_addr < AddrSharedFirst)) ||
                       ((bank == BankDummySome) &&
                        ((new_addr <= AddrDummyLast) || (new_addr == AddrDummyExtra)));

  assign rp_word = {ptr_q[1], ptr_q[0]};
  assign wp_word = {ptr_q[3], ptr_q[2]};
  assign rp_cur  = rp_word[BufAw-1:0];
  assign wp_cur  = wp_word[BufAw-1:0];
  assign rp_inc  = rp_cur + 1'b1;
  assign wp_inc  = wp_cur + 1'b1;

  assign reg_raddr_o = idx;
  assign buf_raddr_o = rp_cur;
  assign buf_waddr_o = wp_cur;
  assign buf_wdata_o = mosi_byte_i;

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    addr_d      = addr_q;
    bank_sel_d  = bank_sel_q;
    ptr_d       = ptr_q;
    clear_all_o = 1'b0;
    reg_re_o    = 1'b0;
    buf_re_o    = 1'b0;
    buf_we_o    = 1'b0;
    req_o.src   = SrcConst;
    req_o.value = '0;
    req_o.wr    = 1'b0;
    req_o.op    = opcode_q;
    req_o.idx   = idx;
    req_o.data  = mosi_byte_i;
    if (accept_i) begin
      if (frame_start_i) begin
        opcode_d = opcode_e'(mosi_byte_i[7:5]);
        addr_d   = new_addr;
        phase_d  = PhData;
        case (opcode_e'(mosi_byte_i[7:5]))
          OpRdReg: begin
            if (needs_dummy) begin
              phase_d = PhDummy;
            end
          end
          OpReset: begin
            phase_d     = PhDone;
            clear_all_o = 1'b1;
            bank_sel_d  = '0;
            ptr_d       = '0;
          end
          OpUnused: phase_d = PhDone;
          default: ;
        endcase
      end else begin
        case (phase_q)
          PhDummy: phase_d = PhData;
          PhData: begin
            case (opcode_q)
              OpRdReg: begin
                if (is_shadow) begin
                  req_o.value = shadow_val;
                end else begin
                  req_o.src = SrcReg;
                  reg_re_o  = 1'b1;
                end
              end
              OpRdBuf: begin
                req_o.src = SrcBuf;
                buf_re_o  = 1'b1;
                {ptr_d[1], ptr_d[0]} = 16'(rp_inc);
              end
              OpWrBuf: begin
                buf_we_o = 1'b1;
                {ptr_d[3], ptr_d[2]} = 16'(wp_inc);
              end
              OpWrReg, OpBitSet, OpBitClr: begin
                phase_d = PhDone;
                if (is_shadow) begin
                  if (idx == IdxBankSel) begin
                    bank_sel_d = shadow_new;
                  end else begin
                    ptr_d[idx[1:0]] = shadow_new;
                  end
                end else begin
                  reg_re_o = 1'b1;
                  req_o.wr = 1'b1;
                end
              end
              default: phase_d = PhDone;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      opcode_q   <= OpRdReg;
      addr_q     <= '0;
      bank_sel_q <= '0;
      ptr_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      addr_q     <= addr_d;
      bank_sel_q <= bank_sel_d;
      ptr_q      <= ptr_d;
    end
  end

endmodule

@@ hdl/sbrc_back.sv @@
// Memory stage: register read-modify-write, entry valid bits and output register.
module sbrc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  sbrc_pkg::s0_req_t            req_i,
  input  logic                         clear_all_i,
  input  logic [7:0]                   reg_rdata_i,
  input  logic [7:0]                   buf_rdata_i,
  output logic                         reg_we_o,
  output logic [sbrc_pkg::RegAw-1:0]   reg_waddr_o,
  output logic [7:0]                   reg_wdata_o,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_data_o
);
  import sbrc_pkg::*;

  logic [RegDepth-1:0] vld_q, vld_d;
  logic                s1_valid_q;
  s0_req_t             s1_q;
  logic                s1_vld_q;
  logic                out_valid_q;
  logic [7:0]          out_data_q;
  logic                adv;
  logic [7:0]          old_val;
  logic [7:0]          miso;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  // An entry not written since reset or a reset command reads as zero.
  assign old_val = s1_vld_q ? reg_rdata_i : 8'h00;

  always_comb begin
    case (s1_q.src)
      SrcReg:  miso = old_val;
      SrcBuf:  miso = buf_rdata_i;
      default: miso = s1_q.value;
    endcase
  end

  always_comb begin
    case (s1_q.op)
      OpWrReg:  reg_wdata_o = s1_q.data;
      OpBitSet: reg_wdata_o = old_val | s1_q.data;
      default:  reg_wdata_o = old_val & ~s1_q.data;
    endcase
  end

  assign reg_we_o    = adv && s1_q.wr;
  assign reg_waddr_o = s1_q.idx;

  // A reset command always follows the write in item order, so it wins.
  always_comb begin
    vld_d = vld_q;
    if (clear_all_i) begin
      vld_d = '0;
    end else if (reg_we_o) begin
      vld_d[s1_q.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q     <= req_i;
      s1_vld_q <= vld_q[req_i.idx];
    end
    if (adv) begin
      out_data_q <= miso;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
